// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each check is clocked on the rising
// edge and switched off while the synchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lfrp_pkg.sv =====
package lfrp_pkg;

  // Frame sections
  typedef enum logic [2:0] {
    SEC_TIME  = 3'd0,
    SEC_FADE  = 3'd1,
    SEC_PWM   = 3'd2,
    SEC_STRIP = 3'd3,
    SEC_SUM   = 3'd4
  } section_t;

  // Result kinds
  localparam logic [2:0] KIND_TIMESTAMP = 3'd0;
  localparam logic [2:0] KIND_FADE      = 3'd1;
  localparam logic [2:0] KIND_PWM_PIX   = 3'd2;
  localparam logic [2:0] KIND_STRIP_PIX = 3'd3;
  localparam logic [2:0] KIND_FRAME_OK  = 3'd4;
  localparam logic [2:0] KIND_SUM_ERR   = 3'd5;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_PWM_COUNT   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_STRIP_COUNT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_STRIP_LENS  = 2'd2;

  // Packed strip length slots in the strip length register
  localparam int unsigned STRIP_SLOTS = 8;

  typedef struct packed {
    logic        frame_last;
    logic [7:0]  blue;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  pixel_index;
    logic [2:0]  strip_index;
    logic [31:0] word_value;
    logic [2:0]  kind;
  } result_t;

endpackage

// ===== rtl/core/lfrp_parser.sv =====
module lfrp_parser #(
  parameter int unsigned MAX_PWM_PIXELS = 16,
  parameter int unsigned MAX_STRIPS     = 8,
  parameter int unsigned MAX_STRIP_LEDS = 255
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lfrp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [63:0]                     cfg_wdata,
  input  logic                            in_fire,
  input  logic [7:0]                      in_byte,
  output logic                            res_valid,
  output lfrp_pkg::result_t               res
);

  // Configuration
  logic [4:0]  pwm_cnt_r;
  logic [3:0]  strip_cnt_r;
  logic [63:0] strip_lens_r;

  // Parse state
  lfrp_pkg::section_t sec_r, sec_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [7:0]  pix_r, pix_nxt;
  logic [2:0]  strip_r, strip_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [31:0] wa_r, wa_nxt;
  logic [7:0]  green_r, green_nxt;
  logic [7:0]  red_r, red_nxt;

  // Derived limits
  logic [7:0]  eff_pwm;
  logic [3:0]  eff_strips;
  logic [7:0]  len_clamp [lfrp_pkg::STRIP_SLOTS];
  logic [3:0]  search_start;
  logic [lfrp_pkg::STRIP_SLOTS-1:0] hit;
  logic        found;
  logic [2:0]  found_idx;
  logic        pix_done;
  logic [31:0] byte_sh;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_cnt_r    <= '0;
      strip_cnt_r  <= '0;
      strip_lens_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        lfrp_pkg::CFG_PWM_COUNT:   pwm_cnt_r    <= cfg_wdata[4:0];
        lfrp_pkg::CFG_STRIP_COUNT: strip_cnt_r  <= cfg_wdata[3:0];
        lfrp_pkg::CFG_STRIP_LENS:  strip_lens_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp counts to the configured maxima
  assign eff_pwm = ({3'b000, pwm_cnt_r} > 8'(MAX_PWM_PIXELS)) ? 8'(MAX_PWM_PIXELS)
                                                             : {3'b000, pwm_cnt_r};
  assign eff_strips = (strip_cnt_r > 4'(MAX_STRIPS)) ? 4'(MAX_STRIPS) : strip_cnt_r;

  // Find the next nonempty strip at or after the search start
  assign search_start = (sec_r == lfrp_pkg::SEC_STRIP) ? ({1'b0, strip_r} + 4'd1) : 4'd0;

  always_comb begin
    found_idx = '0;
    for (int s = 0; s < lfrp_pkg::STRIP_SLOTS; s++) begin
      len_clamp[s] = (strip_lens_r[s*8 +: 8] > 8'(MAX_STRIP_LEDS)) ? 8'(MAX_STRIP_LEDS)
                                                                  : strip_lens_r[s*8 +: 8];
      hit[s] = (4'(s) >= search_start) && (4'(s) < eff_strips) && (len_clamp[s] != 8'd0);
    end
    for (int s = lfrp_pkg::STRIP_SLOTS - 1; s >= 0; s--) begin
      if (hit[s]) found_idx = 3'(s);
    end
  end

  assign found = |hit;

  // Pixel completes the current run
  assign pix_done = (sec_r == lfrp_pkg::SEC_PWM)
                  ? (({1'b0, pix_r} + 9'd1) >= {1'b0, eff_pwm})
                  : (({1'b0, pix_r} + 9'd1) >= {1'b0, len_clamp[strip_r]});

  // Little-endian word assembly
  assign byte_sh = {24'd0, in_byte} << {pos_r, 3'b000};
  assign wa_nxt  = ((pos_r == 2'd0) ? 32'd0 : wa_r) | byte_sh;

  // Next state
  always_comb begin
    sec_nxt   = sec_r;
    pos_nxt   = pos_r;
    pix_nxt   = pix_r;
    strip_nxt = strip_r;
    sum_nxt   = sum_r;
    green_nxt = green_r;
    red_nxt   = red_r;
    case (sec_r)
      lfrp_pkg::SEC_TIME, lfrp_pkg::SEC_SUM: begin
        if (sec_r == lfrp_pkg::SEC_TIME) sum_nxt = sum_r + {24'd0, in_byte};
        if (pos_r != 2'd3) begin
          pos_nxt = pos_r + 2'd1;
        end else begin
          pos_nxt = 2'd0;
          if (sec_r == lfrp_pkg::SEC_TIME) begin
            sec_nxt = lfrp_pkg::SEC_FADE;
          end else begin
            sec_nxt   = lfrp_pkg::SEC_TIME;
            sum_nxt   = '0;
            pix_nxt   = '0;
            strip_nxt = '0;
          end
        end
      end
      lfrp_pkg::SEC_FADE: begin
        sum_nxt = sum_r + {24'd0, in_byte};
        pos_nxt = 2'd0;
        pix_nxt = '0;
        if (eff_pwm != 8'd0) begin
          sec_nxt = lfrp_pkg::SEC_PWM;
        end else if (found) begin
          sec_nxt   = lfrp_pkg::SEC_STRIP;
          strip_nxt = found_idx;
        end else begin
          sec_nxt   = lfrp_pkg::SEC_SUM;
          strip_nxt = '0;
        end
      end
      lfrp_pkg::SEC_PWM, lfrp_pkg::SEC_STRIP: begin
        sum_nxt = sum_r + {24'd0, in_byte};
        if (pos_r == 2'd0) begin
          green_nxt = in_byte;
          pos_nxt   = 2'd1;
        end else if (pos_r == 2'd1) begin
          red_nxt = in_byte;
          pos_nxt = 2'd2;
        end else begin
          pos_nxt = 2'd0;
          if (pix_done) begin
            pix_nxt = '0;
            if (found) begin
              sec_nxt   = lfrp_pkg::SEC_STRIP;
              strip_nxt = found_idx;
            end else begin
              sec_nxt   = lfrp_pkg::SEC_SUM;
              strip_nxt = '0;
            end
          end else begin
            pix_nxt = pix_r + 8'd1;
          end
        end
      end
      default: begin
        sec_nxt = lfrp_pkg::SEC_TIME;
        pos_nxt = 2'd0;
      end
    endcase
  end

  // Result for the current byte
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    case (sec_r)
      lfrp_pkg::SEC_TIME: begin
        res_valid      = (pos_r == 2'd3);
        res.kind       = lfrp_pkg::KIND_TIMESTAMP;
        res.word_value = wa_nxt;
      end
      lfrp_pkg::SEC_SUM: begin
        res_valid      = (pos_r == 2'd3);
        res.kind       = (wa_nxt == sum_r) ? lfrp_pkg::KIND_FRAME_OK : lfrp_pkg::KIND_SUM_ERR;
        res.word_value = sum_r;
        res.frame_last = 1'b1;
      end
      lfrp_pkg::SEC_FADE: begin
        res_valid      = 1'b1;
        res.kind       = lfrp_pkg::KIND_FADE;
        res.word_value = {31'd0, (in_byte != 8'd0)};
      end
      lfrp_pkg::SEC_PWM, lfrp_pkg::SEC_STRIP: begin
        res_valid       = (pos_r[1] == 1'b1);
        res.kind        = (sec_r == lfrp_pkg::SEC_PWM) ? lfrp_pkg::KIND_PWM_PIX
                                                      : lfrp_pkg::KIND_STRIP_PIX;
        res.strip_index = (sec_r == lfrp_pkg::SEC_PWM) ? 3'd0 : strip_r;
        res.pixel_index = pix_r;
        res.green       = green_r;
        res.red         = red_r;
        res.blue        = in_byte;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    res_valid = res_valid && in_fire;
  end

  // Advance parse state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r   <= lfrp_pkg::SEC_TIME;
      pos_r   <= '0;
      pix_r   <= '0;
      strip_r <= '0;
      sum_r   <= '0;
      wa_r    <= '0;
      green_r <= '0;
      red_r   <= '0;
    end else if (in_fire) begin
      sec_r   <= sec_nxt;
      pos_r   <= pos_nxt;
      pix_r   <= pix_nxt;
      strip_r <= strip_nxt;
      sum_r   <= sum_nxt;
      if (sec_r == lfrp_pkg::SEC_TIME || sec_r == lfrp_pkg::SEC_SUM) wa_r <= wa_nxt;
      green_r <= green_nxt;
      red_r   <= red_nxt;
    end
  end

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_sum_restarts, clk, rst_n, res_valid && res.frame_last, (sec_r == lfrp_pkg::SEC_TIME) && (sum_r == 32'd0), "frame end must restart the sum")
  `ASSERT_IMPLY(a_strip_in_range, clk, rst_n, sec_r == lfrp_pkg::SEC_STRIP, {1'b0, strip_r} < eff_strips, "strip counter past strip count")

endmodule

// ===== rtl/core/lfrp_out_buf.sv =====
module lfrp_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lfrp_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output lfrp_pkg::result_t out_data
);

  // Output register plus one skid entry
  lfrp_pkg::result_t head_r, skid_r;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              pop;

  assign pop       = (cnt_r != 2'd0) && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = head_r;
  assign space     = (cnt_r != 2'd2);

  // Occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Move payload: when full, refill head from skid on a pop; else fill head when empty or draining, else park in skid
  always_ff @(posedge clk) begin
    if (cnt_r == 2'd2) begin
      if (pop) head_r <= skid_r;
    end else if (push) begin
      if (cnt_r == 2'd0 || pop) head_r <= push_data;
      else skid_r <= push_data;
    end
  end

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r != 2'd3, "buffer count overflow")
  `ASSERT_IMPLY(a_no_push_full, clk, rst_n, push, cnt_r != 2'd2, "push into full buffer")
  `ASSERT_NEXT(a_full_hold, clk, rst_n, (cnt_r == 2'd2) && !out_ready, (cnt_r == 2'd2) && $stable(head_r), "full buffer lost data")

endmodule

// ===== rtl/core/led_frame_record_parser_top.sv =====
// Output: each result is registered in the output buffer and leaves on the out_ port behind any held there.
// Throughput: one byte per cycle; the two-entry output buffer keeps in_tready high while
// the consumer takes one result per cycle, and drops it only when both entries are held.
// Reset: synchronous, active low; clears configuration, parse state and buffered results,
// and holds in_tready low.
module led_frame_record_parser_top #(
  parameter int unsigned MAX_PWM_PIXELS = 16,
  parameter int unsigned MAX_STRIPS     = 8,
  parameter int unsigned MAX_STRIP_LEDS = 255
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lfrp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [63:0]                     cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] data_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] word_value, [34:32] strip_index, [42:35] pixel_index,
  // [50:43] green, [58:51] red, [66:59] blue, [71:67] zero
  output logic [71:0]                     out_tdata,
  output logic [2:0]                      out_tuser,  // [2:0] kind
  output logic                            out_tlast   // frame_last
);

  logic              in_fire;
  logic              res_valid;
  lfrp_pkg::result_t res;
  lfrp_pkg::result_t out_res;
  logic              space;

  assign in_tready = space && rst_n;
  assign in_fire   = in_tvalid && in_tready;

  lfrp_parser #(
    .MAX_PWM_PIXELS (MAX_PWM_PIXELS),
    .MAX_STRIPS     (MAX_STRIPS),
    .MAX_STRIP_LEDS (MAX_STRIP_LEDS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  lfrp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  // Pack the result transaction
  assign out_tdata = {5'd0, out_res.blue, out_res.red, out_res.green,
                      out_res.pixel_index, out_res.strip_index, out_res.word_value};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.frame_last;

endmodule
